/* hw/rtl/slcfp_pkg.sv */
package slcfp_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] REG_SYNC_BYTE  = 2'd0;
  localparam logic [1:0] REG_MIN_LENGTH = 2'd1;
  localparam logic [1:0] REG_MAX_LENGTH = 2'd2;

  // register reset values
  localparam logic [7:0] SYNC_BYTE_RST  = 8'd200;
  localparam logic [7:0] MIN_LENGTH_RST = 8'd2;
  localparam logic [7:0] MAX_LENGTH_RST = 8'd62;

  // a frame needs at least a type byte and a crc byte
  localparam logic [7:0] LENGTH_FLOOR = 8'd2;

  // crc-8, msb first
  localparam logic [7:0] CRC_TOP  = 8'h80;
  localparam logic [7:0] CRC_POLY = 8'hD5;

  typedef enum logic [1:0] {
    PH_SEEK = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_REJECT = 2'd1,
    ST_GOOD   = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] sync_byte;
    logic [7:0] min_length;
    logic [7:0] max_length;
  } cfg_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
    logic       byte_valid;
    logic [7:0] byte_index;
    logic [7:0] body_byte;
  } result_t;

  // one byte of crc update, eight shift steps unrolled
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 8'd0) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

/* hw/rtl/slcfp_parser.sv */
module slcfp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  slcfp_pkg::cfg_t    cfg,
  output slcfp_pkg::result_t res
);
  import slcfp_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] length_r, length_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [7:0] type_r, type_nxt;

  // parse state, updated once per processed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEEK;
      length_r <= 8'd0;
      count_r  <= 8'd0;
      crc_r    <= 8'd0;
      type_r   <= 8'd0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      length_r <= length_nxt;
      count_r  <= count_nxt;
      crc_r    <= crc_nxt;
      type_r   <= type_nxt;
    end
  end

  // next state and result for the current byte
  always_comb begin
    phase_nxt  = phase_r;
    length_nxt = length_r;
    count_nxt  = count_r;
    crc_nxt    = crc_r;
    type_nxt   = type_r;
    res        = '0;
    res.status = ST_NONE;

    unique case (phase_r)
      PH_LEN: begin
        res.frame_length = rx_byte;
        if (rx_byte < LENGTH_FLOOR || rx_byte < cfg.min_length ||
            rx_byte > cfg.max_length) begin
          phase_nxt  = PH_SEEK;
          res.status = ST_REJECT;
        end else begin
          length_nxt = rx_byte;
          count_nxt  = 8'd0;
          crc_nxt    = 8'd0;
          type_nxt   = 8'd0;
          phase_nxt  = PH_BODY;
        end
      end
      PH_BODY: begin
        res.frame_length = length_r;
        if (count_r < length_r - 8'd1) begin
          if (count_r == 8'd0) begin
            type_nxt = rx_byte;
          end
          crc_nxt        = crc8_update(crc_r, rx_byte);
          res.byte_valid = 1'b1;
          res.byte_index = count_r;
          res.body_byte  = rx_byte;
          count_nxt      = count_r + 8'd1;
        end else begin
          phase_nxt = PH_SEEK;
          if (crc_r != rx_byte) begin
            res.status = ST_REJECT;
          end else begin
            res.status     = ST_GOOD;
            res.frame_type = type_r;
          end
        end
      end
      default: begin
        // hunting for sync
        phase_nxt = (rx_byte == cfg.sync_byte) ? PH_LEN : PH_SEEK;
      end
    endcase
  end

endmodule

/* hw/rtl/sync_length_crc8_frame_parser_unit.sv */
// a beat accepted at the input moves through the input register and then the result register
// throughput: one beat per cycle unless out_tready stalls the output, set by the
// combinational parse step and crc update between the input and result registers
// reset: synchronous active-low rst_n clears both stages, the parse state to sync hunt,
// and the configuration registers to sync 200, min length 2, max length 62
module sync_length_crc8_frame_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] frame_type, [15:8] frame_length,
                                  // [23:16] byte_index, [31:24] body_byte
  output logic [2:0]  out_tuser   // [1:0] status, [2] byte_valid
);
  import slcfp_pkg::*;

  cfg_t       cfg_r;
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       out_v_r;
  result_t    out_r;
  result_t    res;
  logic       adv;
  logic       step;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_byte  <= SYNC_BYTE_RST;
      cfg_r.min_length <= MIN_LENGTH_RST;
      cfg_r.max_length <= MAX_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SYNC_BYTE:  cfg_r.sync_byte  <= cfg_wdata;
        REG_MIN_LENGTH: cfg_r.min_length <= cfg_wdata;
        REG_MAX_LENGTH: cfg_r.max_length <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign adv       = !out_v_r || out_tready;
  assign step      = in_v_r && adv;
  assign in_tready = !in_v_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  slcfp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_r.body_byte, out_r.byte_index, out_r.frame_length, out_r.frame_type};
  assign out_tuser  = {out_r.byte_valid, out_r.status};

  // a processed beat always lands in the result register
  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_v_r)
    else $error("processed beat did not reach result register");

  // a body byte beat never carries a frame verdict
  a_body_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.byte_valid) |-> (out_r.status == ST_NONE))
    else $error("body byte beat carries a status");

  // body byte index stays below the frame length
  a_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.byte_valid) |-> (out_r.byte_index < out_r.frame_length))
    else $error("body byte index beyond frame length");

  // a good frame always had an accepted length
  a_good_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.status == ST_GOOD) |-> (out_r.frame_length >= LENGTH_FLOOR))
    else $error("good frame with short length");

endmodule
